>>> rtl/core/ted_pkg.sv
// Package for the touch event decoder: event and touch item types,
// event type and code constants, record kinds.
// No dependencies; used by touch_event_decoder.
`timescale 1ns / 1ps
`default_nettype none

package ted_pkg;

    // Coordinate storage width default and limits
    localparam int COORD_BITS_DEFAULT = 16;
    localparam int COORD_BITS_MAX     = 32;
    localparam int OUT_COORD_BITS     = 16;

    // Event types
    localparam logic [15:0] EV_SYNC = 16'd0;
    localparam logic [15:0] EV_KEY  = 16'd1;
    localparam logic [15:0] EV_ABS  = 16'd3;

    // Event codes
    localparam logic [15:0] CODE_REPORT   = 16'd2;
    localparam logic [15:0] CODE_X        = 16'd53;
    localparam logic [15:0] CODE_Y        = 16'd54;
    localparam logic [15:0] CODE_TRACK_ID = 16'd57;
    localparam logic [15:0] CODE_TOUCH    = 16'd330;

    // Key states
    localparam logic signed [31:0] KEY_UP   = 32'sd0;
    localparam logic signed [31:0] KEY_DOWN = 32'sd1;

    // Tracking bit positions
    localparam int TRK_ARMED  = 0;
    localparam int TRK_X_SEEN = 1;
    localparam int TRK_Y_SEEN = 2;
    localparam logic [2:0] TRK_NONE = 3'b000;
    localparam logic [2:0] TRK_ARM  = 3'b001;
    localparam logic [2:0] TRK_FULL = 3'b111;

    // Sync count levels
    localparam logic [1:0] SYNC_RELEASE = 2'd2;
    localparam logic [1:0] SYNC_SAT     = 2'd3;

    // Record kinds
    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_PRESS   = 1'b1;

    typedef struct packed {
        logic [15:0]        event_type;
        logic [15:0]        event_code;
        logic signed [31:0] event_value;
    } event_t;

    typedef struct packed {
        logic        touch_kind;
        logic [15:0] touch_x;
        logic [15:0] touch_y;
    } touch_t;

endpackage

`default_nettype wire

>>> rtl/core/touch_event_decoder.sv
// Touch event decoder top level: input event register, decode logic,
// tracking state and touch record register.
// Depends on ted_pkg.
`timescale 1ns / 1ps
`default_nettype none

// An event is registered on acceptance; its record, if any, is registered when
// the event is decoded, which waits while an untaken record still holds the
// record register.
// Throughput: one event per cycle while m_ready is high; the single decode pass
// between the input register and the record register sets that rate.
// Reset (aresetn low, synchronous): both stages empty, tracking disarmed, sync
// count and contact cleared, coordinates zero, last reported point all ones.
module touch_event_decoder #(
    parameter int COORD_BITS = ted_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // configuration
    input  wire logic            cfg_wr_en,
    input  wire logic            cfg_wr_data,
    // event input channel
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire ted_pkg::event_t s_event,
    // touch record channel
    output logic                 m_valid,
    input  wire logic            m_ready,
    output ted_pkg::touch_t      m_touch
);

    // Configuration
    logic                  sync_mode_reg;

    // Input stage
    logic                  in_valid_reg;
    ted_pkg::event_t       in_event_reg;

    // Tracking state
    logic [2:0]            track_reg,   track_next;
    logic [1:0]            sync_reg,    sync_next;
    logic                  contact_reg, contact_next;
    logic [COORD_BITS-1:0] cur_x_reg,   cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg,   cur_y_next;
    logic [COORD_BITS-1:0] prev_x_reg,  prev_x_next;
    logic [COORD_BITS-1:0] prev_y_reg,  prev_y_next;

    // Output stage
    logic                  out_valid_reg;
    ted_pkg::touch_t       out_touch_reg;

    // Decode results
    logic                  emit;
    logic                  emit_kind;
    logic                  advance;
    logic                  is_touch_key;
    logic [COORD_BITS-1:0] value_coord;
    logic [ted_pkg::COORD_BITS_MAX-1:0] x_wide;
    logic [ted_pkg::COORD_BITS_MAX-1:0] y_wide;

    // Move the held event into decode whenever the record slot is free or
    // being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_touch = out_touch_reg;

    assign is_touch_key = (in_event_reg.event_type == ted_pkg::EV_KEY) &&
                          (in_event_reg.event_code == ted_pkg::CODE_TOUCH);
    assign value_coord  = in_event_reg.event_value[COORD_BITS-1:0];

    // Decode one event against the tracking state
    always_comb begin
        track_next   = track_reg;
        sync_next    = sync_reg;
        contact_next = contact_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        emit         = 1'b0;
        emit_kind    = ted_pkg::KIND_RELEASE;

        if ((track_reg == ted_pkg::TRK_NONE &&
             in_event_reg.event_type == ted_pkg::EV_ABS &&
             in_event_reg.event_code == ted_pkg::CODE_TRACK_ID) ||
            (is_touch_key && in_event_reg.event_value == ted_pkg::KEY_DOWN)) begin
            // arm (or re-arm) tracking
            track_next = ted_pkg::TRK_ARM;
            sync_next  = '0;
        end else if (is_touch_key && in_event_reg.event_value == ted_pkg::KEY_UP) begin
            // key up: disarm, release if in contact
            track_next = ted_pkg::TRK_NONE;
            if (contact_reg) begin
                contact_next = 1'b0;
                emit         = 1'b1;
                emit_kind    = ted_pkg::KIND_RELEASE;
            end
        end else if (track_reg != ted_pkg::TRK_NONE &&
                     in_event_reg.event_type == ted_pkg::EV_ABS) begin
            // latch coordinates while armed
            sync_next = '0;
            if (in_event_reg.event_code == ted_pkg::CODE_X) begin
                cur_x_next                      = value_coord;
                track_next[ted_pkg::TRK_X_SEEN] = 1'b1;
            end else if (in_event_reg.event_code == ted_pkg::CODE_Y) begin
                cur_y_next                      = value_coord;
                track_next[ted_pkg::TRK_Y_SEEN] = 1'b1;
            end
            // press/move once both axes are seen, drop a repeated point
            if (track_next == ted_pkg::TRK_FULL &&
                !(contact_reg && cur_x_next == prev_x_reg &&
                  cur_y_next == prev_y_reg)) begin
                prev_x_next  = cur_x_next;
                prev_y_next  = cur_y_next;
                contact_next = 1'b1;
                emit         = 1'b1;
                emit_kind    = ted_pkg::KIND_PRESS;
            end
        end else if (in_event_reg.event_type == ted_pkg::EV_SYNC) begin
            // sync events only matter in sync release mode
            if (sync_mode_reg) begin
                track_next = ted_pkg::TRK_NONE;
                if (in_event_reg.event_code == ted_pkg::CODE_REPORT &&
                    sync_reg != ted_pkg::SYNC_SAT) begin
                    sync_next = sync_reg + 2'd1;
                end
                if (sync_next == ted_pkg::SYNC_RELEASE && contact_reg) begin
                    contact_next = 1'b0;
                    emit         = 1'b1;
                    emit_kind    = ted_pkg::KIND_RELEASE;
                end
            end
        end else begin
            // anything else: disarm and clear the sync count
            track_next = ted_pkg::TRK_NONE;
            sync_next  = '0;
        end
    end

    // Widen the coordinates, then take the low output bits of the record
    assign x_wide = ted_pkg::COORD_BITS_MAX'(cur_x_next);
    assign y_wide = ted_pkg::COORD_BITS_MAX'(cur_y_next);

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            sync_mode_reg <= cfg_wr_data;
        end
    end

    // Input stage: take a new item whenever the stage is free or advancing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_event_reg <= s_event;
        end
    end

    // Tracking state: advance only when the held item is decoded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_reg   <= ted_pkg::TRK_NONE;
            sync_reg    <= '0;
            contact_reg <= 1'b0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            prev_x_reg  <= '1;
            prev_y_reg  <= '1;
        end else if (advance) begin
            track_reg   <= track_next;
            sync_reg    <= sync_next;
            contact_reg <= contact_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
        end
    end

    // Record stage: load on a decoded record, clear once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_touch_reg.touch_kind <= emit_kind;
            out_touch_reg.touch_x    <= x_wide[ted_pkg::OUT_COORD_BITS-1:0];
            out_touch_reg.touch_y    <= y_wide[ted_pkg::OUT_COORD_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

>>> sim/touch_event_decoder_tb.sv
// Self-checking testbench for touch_event_decoder: directed gesture tests, then
// random gestures and noise under random stalls, checked against a local predictor.
// Depends on ted_pkg and touch_event_decoder.
`timescale 1ns / 1ps

module touch_event_decoder_tb;

    localparam int RANDOM_EVENTS = 500;
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 4;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            cfg_wr_en = 1'b0;
    logic            cfg_wr_data = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    ted_pkg::event_t s_event = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    ted_pkg::touch_t m_touch;

    // Predicted decoder state, kept in step with every accepted event
    bit          release_on_sync = 1'b0;
    logic [2:0]  arm_bits = ted_pkg::TRK_NONE;
    logic [1:0]  report_count = '0;
    bit          contact = 1'b0;
    logic [15:0] lat_x = '0;
    logic [15:0] lat_y = '0;
    logic [15:0] last_x = 16'hFFFF;
    logic [15:0] last_y = 16'hFFFF;

    ted_pkg::touch_t pending_touches[$];
    ted_pkg::touch_t want_rec;
    bit     idle_en = 1'b1;
    int     errors = 0;
    int     events_sent = 0;
    int     presses_seen = 0;
    int     releases_seen = 0;

    touch_event_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_event     (s_event),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_touch     (m_touch)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the record channel about 18 times in a hundred while idling is on
    always @(posedge aclk) begin
        m_ready <= (idle_en && $urandom_range(99) < 18) ? 1'b0 : 1'b1;
    end

    // Predict the record (if any) caused by one event and advance the state.
    function automatic bit decode_event(input ted_pkg::event_t ev,
                                        output ted_pkg::touch_t rec);
        bit touch_key;
        bit hit;
        touch_key = ev.event_type == ted_pkg::EV_KEY &&
                    ev.event_code == ted_pkg::CODE_TOUCH;
        hit = 1'b0;
        rec = '0;
        if ((arm_bits == ted_pkg::TRK_NONE && ev.event_type == ted_pkg::EV_ABS &&
             ev.event_code == ted_pkg::CODE_TRACK_ID) ||
            (touch_key && ev.event_value == ted_pkg::KEY_DOWN)) begin
            // arm (or re-arm): forget seen coordinates and the sync count
            arm_bits = ted_pkg::TRK_ARM;
            report_count = '0;
        end else if (touch_key && ev.event_value == ted_pkg::KEY_UP) begin
            arm_bits = ted_pkg::TRK_NONE;
            if (contact) begin
                contact = 1'b0;
                rec.touch_kind = ted_pkg::KIND_RELEASE;
                hit = 1'b1;
            end
        end else if (arm_bits != ted_pkg::TRK_NONE && ev.event_type == ted_pkg::EV_ABS) begin
            report_count = '0;
            if (ev.event_code == ted_pkg::CODE_X) begin
                lat_x = ev.event_value[15:0];
                arm_bits[ted_pkg::TRK_X_SEEN] = 1'b1;
            end else if (ev.event_code == ted_pkg::CODE_Y) begin
                lat_y = ev.event_value[15:0];
                arm_bits[ted_pkg::TRK_Y_SEEN] = 1'b1;
            end
            // suppress a repeat of the reported point while touching
            if (arm_bits == ted_pkg::TRK_FULL &&
                !(contact && lat_x == last_x && lat_y == last_y)) begin
                last_x = lat_x;
                last_y = lat_y;
                contact = 1'b1;
                rec.touch_kind = ted_pkg::KIND_PRESS;
                hit = 1'b1;
            end
        end else if (ev.event_type == ted_pkg::EV_SYNC) begin
            if (release_on_sync) begin
                arm_bits = ted_pkg::TRK_NONE;
                if (ev.event_code == ted_pkg::CODE_REPORT &&
                    report_count != ted_pkg::SYNC_SAT)
                    report_count = report_count + 2'd1;
                if (report_count == ted_pkg::SYNC_RELEASE && contact) begin
                    contact = 1'b0;
                    rec.touch_kind = ted_pkg::KIND_RELEASE;
                    hit = 1'b1;
                end
            end
        end else begin
            arm_bits = ted_pkg::TRK_NONE;
            report_count = '0;
        end
        rec.touch_x = lat_x;
        rec.touch_y = lat_y;
        return hit;
    endfunction

    // Present one event, hold it until accepted, then queue its predicted record.
    task automatic send_event(input logic [15:0] etype, input logic [15:0] ecode,
                              input logic signed [31:0] evalue);
        ted_pkg::event_t ev;
        ted_pkg::touch_t rec;
        ev.event_type  = etype;
        ev.event_code  = ecode;
        ev.event_value = evalue;
        while (idle_en && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_event <= ev;
        do @(posedge aclk); while (!s_ready);
        events_sent++;
        if (decode_event(ev, rec))
            pending_touches.push_back(rec);
    endtask

    // Drop valid, wait for every outstanding record, then let the pipe settle.
    task automatic drain_records();
        s_valid <= 1'b0;
        while (pending_touches.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_release_mode(input bit mode);
        drain_records();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        release_on_sync = mode;
    endtask

    // Compare every accepted record with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_touches.size() == 0) begin
                $error("unexpected record: kind %0d x %0d y %0d",
                       m_touch.touch_kind, m_touch.touch_x, m_touch.touch_y);
                errors++;
            end else begin
                want_rec = pending_touches.pop_front();
                if (m_touch.touch_kind !== want_rec.touch_kind) begin
                    $error("touch_kind: expected %0d, got %0d",
                           want_rec.touch_kind, m_touch.touch_kind);
                    errors++;
                end
                if (m_touch.touch_x !== want_rec.touch_x) begin
                    $error("touch_x: expected %0d, got %0d",
                           want_rec.touch_x, m_touch.touch_x);
                    errors++;
                end
                if (m_touch.touch_y !== want_rec.touch_y) begin
                    $error("touch_y: expected %0d, got %0d",
                           want_rec.touch_y, m_touch.touch_y);
                    errors++;
                end
                if (want_rec.touch_kind == ted_pkg::KIND_PRESS)
                    presses_seen++;
                else
                    releases_seen++;
            end
        end
    end

    // Arm by tracking id straight after reset; the first point equals the
    // all-ones last point but must still report since nothing is in contact.
    task automatic test_tracking_id();
        send_event(ted_pkg::EV_ABS, ted_pkg::CODE_TRACK_ID, 32'sd0);
        send_event(ted_pkg::EV_ABS, ted_pkg::CODE_X, 32'sh7FFF_FFFF);
        send_event(ted_pkg::EV_ABS, ted_pkg::CODE_Y, -32'sd1);
        // tracking id while armed: same point in contact, no record
        send_event(ted_pkg::EV_ABS, ted_pkg::CODE_TRACK_ID, 32'sd5);
        // key down while armed re-arms; X alone is not enough for a record
        send_event(ted_pkg::EV_KEY, ted_pkg::CODE_TOUCH, ted_pkg::KEY_DOWN);
        send_event(ted_pkg::EV_ABS, ted_pkg::CODE_X, 32'sh8000_0000);
        send_event(ted_pkg::EV_KEY, ted_pkg::CODE_TOUCH, ted_pkg::KEY_UP);
    endtask

    // Press, unchanged point, move, release, stray key-up; sync is ignored in mode 0
    task automatic test_press_move_release();
        send_event(ted_pkg::EV_KEY, ted_pkg::CODE_TOUCH, ted_pkg::KEY_DOWN);
        send_event(ted_pkg::EV_ABS, ted_pkg::CODE_X, 32'sd100);
        send_event(ted_pkg::EV_ABS, ted_pkg::CODE_Y, 32'sd200);
        send_event(ted_pkg::EV_ABS, ted_pkg::CODE_Y, 32'sd200);
        send_event(ted_pkg::EV_SYNC, ted_pkg::CODE_REPORT, 32'sd0);
        send_event(ted_pkg::EV_ABS, ted_pkg::CODE_X, 32'sd101);
        send_event(ted_pkg::EV_KEY, ted_pkg::CODE_TOUCH, ted_pkg::KEY_UP);
        send_event(ted_pkg::EV_KEY, ted_pkg::CODE_TOUCH, ted_pkg::KEY_UP);
    endtask

    // Odd key values, other key codes, unknown types and unarmed axis events disarm
    task automatic test_ignored_events();
        send_event(ted_pkg::EV_KEY, ted_pkg::CODE_TOUCH, 32'sd2);
        send_event(ted_pkg::EV_KEY, 16'd331, ted_pkg::KEY_DOWN);
        send_event(16'hFFFF, 16'hFFFF, 32'sh5555_AAAA);
        send_event(ted_pkg::EV_ABS, ted_pkg::CODE_X, 32'sd77);
    endtask

    // Release on the second report sync, saturation, and non-report sync
    task automatic test_sync_release();
        write_release_mode(1'b1);
        send_event(ted_pkg::EV_KEY, ted_pkg::CODE_TOUCH, ted_pkg::KEY_DOWN);
        send_event(ted_pkg::EV_ABS, ted_pkg::CODE_X, 32'sd5);
        send_event(ted_pkg::EV_ABS, ted_pkg::CODE_Y, 32'sd6);
        send_event(ted_pkg::EV_SYNC, ted_pkg::CODE_REPORT, 32'sd0);
        send_event(ted_pkg::EV_SYNC, ted_pkg::CODE_REPORT, 32'sd0);
        send_event(ted_pkg::EV_SYNC, ted_pkg::CODE_REPORT, 32'sd0);
        send_event(ted_pkg::EV_SYNC, 16'd0, 32'sd0);
    endtask

    // Half of the coordinates come from a small pool so unchanged points recur
    function automatic logic signed [31:0] pick_coord();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return 32'($urandom_range(3));
        else if (roll < 80)
            return 32'($urandom_range(65535));
        return $urandom;
    endfunction

    task automatic random_noise();
        case ($urandom_range(3))
            0: send_event(16'($urandom), 16'($urandom), $urandom);
            1: send_event(ted_pkg::EV_KEY, ted_pkg::CODE_TOUCH,
                          32'($urandom_range(3)) - 32'sd1);
            2: send_event(ted_pkg::EV_SYNC, 16'($urandom_range(3)), $urandom);
            default: send_event(ted_pkg::EV_ABS, 16'($urandom_range(52, 58)), pick_coord());
        endcase
    endtask

    // One touch from arm to release, with random frames and endings
    task automatic random_gesture();
        int frames;
        frames = $urandom_range(1, 6);
        if ($urandom_range(1))
            send_event(ted_pkg::EV_KEY, ted_pkg::CODE_TOUCH, ted_pkg::KEY_DOWN);
        else
            send_event(ted_pkg::EV_ABS, ted_pkg::CODE_TRACK_ID, $urandom);
        repeat (frames) begin
            if (release_on_sync || $urandom_range(3) == 0)
                send_event(ted_pkg::EV_ABS, ted_pkg::CODE_TRACK_ID, $urandom);
            if ($urandom_range(1)) begin
                if ($urandom_range(7) != 0)
                    send_event(ted_pkg::EV_ABS, ted_pkg::CODE_X, pick_coord());
                if ($urandom_range(7) != 0)
                    send_event(ted_pkg::EV_ABS, ted_pkg::CODE_Y, pick_coord());
            end else begin
                if ($urandom_range(7) != 0)
                    send_event(ted_pkg::EV_ABS, ted_pkg::CODE_Y, pick_coord());
                if ($urandom_range(7) != 0)
                    send_event(ted_pkg::EV_ABS, ted_pkg::CODE_X, pick_coord());
            end
            if (release_on_sync || $urandom_range(3) == 0)
                send_event(ted_pkg::EV_SYNC, ted_pkg::CODE_REPORT, 32'sd0);
        end
        case ($urandom_range(3))
            0: begin
                send_event(ted_pkg::EV_SYNC, ted_pkg::CODE_REPORT, 32'sd0);
                send_event(ted_pkg::EV_SYNC, ted_pkg::CODE_REPORT, 32'sd0);
            end
            1: ;    // abandon the touch without any release
            default: send_event(ted_pkg::EV_KEY, ted_pkg::CODE_TOUCH, ted_pkg::KEY_UP);
        endcase
    endtask

    // Random phases alternate the release mode; one runs with no idling at all
    task automatic test_random_traffic();
        int phase_end;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_release_mode(p[0]);
            idle_en = (p != 2);
            phase_end = events_sent + RANDOM_EVENTS / RANDOM_PHASES;
            while (events_sent < phase_end) begin
                if ($urandom_range(99) < 15)
                    random_noise();
                else
                    random_gesture();
                // hold the sender until the record channel has caught up
                if ($urandom_range(99) < 3)
                    drain_records();
            end
        end
        idle_en = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_tracking_id();
        write_release_mode(1'b0);
        test_press_move_release();
        test_ignored_events();
        test_sync_release();
        test_random_traffic();

        s_valid <= 1'b0;
        for (int i = 0; i < 2000 && pending_touches.size() != 0; i++)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_touches.size() != 0) begin
            $error("%0d predicted records never arrived", pending_touches.size());
            errors++;
        end
        $display("Sent %0d events (gestures, noise, sync release mode off and on);",
                 events_sent);
        $display("checked %0d press/move and %0d release records.",
                 presses_seen, releases_seen);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
